@@ sv/clamped_edge_image_convolution_core_assert.svh @@
// Assertion macros shared by the convolution core.
`ifndef CLAMPED_EDGE_IMAGE_CONVOLUTION_CORE_ASSERT_SVH
`define CLAMPED_EDGE_IMAGE_CONVOLUTION_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CEC_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define CEC_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

@@ sv/cec_pkg.sv @@
`default_nettype none

package cec_pkg;

   typedef logic [7:0] sample_type;
   // One pixel, channel 0 in the lowest byte.
   typedef sample_type [2:0] pixel_type;
   // One window column, top row in the lowest pixel.
   typedef pixel_type [2:0] column_type;
   // Three window columns: left, center, right.
   typedef column_type [2:0] window_type;

   typedef logic signed [15:0] coef_type;
   typedef coef_type [2:0] kernel_row_type;
   typedef kernel_row_type [2:0] kernel_type;

   localparam int ResultWidth = 29;
   typedef logic signed [ResultWidth-1:0] result_type;
   typedef result_type [2:0] result_set_type;

   localparam logic [12:0] HeightLimit = 13'd4096;

   typedef enum logic [2:0] {
      CSR_KERNEL_TOP    = 3'd0,
      CSR_KERNEL_MIDDLE = 3'd1,
      CSR_KERNEL_BOTTOM = 3'd2,
      CSR_IMAGE_WIDTH   = 3'd3,
      CSR_IMAGE_HEIGHT  = 3'd4,
      CSR_NUM_CHANNELS  = 3'd5,
      CSR_KEEP_CHANNELS = 3'd6
   } csr_index_type;

   typedef struct packed {
      kernel_type kernel;
      logic       ch1_on;
      logic       ch2_on;
      logic       keep;
   } mac_cfg_type;

   typedef struct packed {
      logic prod;
      logic rows;
      logic chans;
      logic result;
   } mac_load_type;

   typedef struct packed {
      logic emit;
      logic right_is_new;
      logic left_from_center;
      logic top_from_a;
      logic bot_from_a;
      logic do_shift;
      logic do_write;
      logic frame_last;
   } s1_ctl_type;

endpackage

`default_nettype wire

@@ sv/cec_column_cell.sv @@
`default_nettype none

// One window column; loads from its neighbor when the window shifts.
module cec_column_cell (
   input  logic                   clock,
   input  logic                   shift,
   input  cec_pkg::column_type    col_in,
   output cec_pkg::column_type    col_out
);

   cec_pkg::column_type col_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

`default_nettype wire

@@ sv/cec_line_store.sv @@
`default_nettype none

// Two line memories with registered reads. A write and a read of the same
// address at one edge return the written data through a bypass.
module cec_line_store #(
   parameter int DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  cec_pkg::pixel_type              wr_pixel,
   input  cec_pkg::pixel_type              wr_above,
   output cec_pkg::pixel_type              rd_a,
   output cec_pkg::pixel_type              rd_b
);

   cec_pkg::pixel_type mem_a [DEPTH];
   cec_pkg::pixel_type mem_b [DEPTH];
   cec_pkg::pixel_type q_a_ff;
   cec_pkg::pixel_type q_b_ff;
   cec_pkg::pixel_type fwd_a_ff;
   cec_pkg::pixel_type fwd_b_ff;
   logic               fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= wr_pixel;
         mem_b[wr_addr] <= wr_above;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_a_ff   <= mem_a[rd_addr];
         q_b_ff   <= mem_b[rd_addr];
         fwd_ff   <= wr_en && (wr_addr == rd_addr);
         fwd_a_ff <= wr_pixel;
         fwd_b_ff <= wr_above;
      end
   end

   assign rd_a = fwd_ff ? fwd_a_ff : q_a_ff;
   assign rd_b = fwd_ff ? fwd_b_ff : q_b_ff;

endmodule

`default_nettype wire

@@ sv/cec_mac.sv @@
`default_nettype none

// Multiply-accumulate for one 3x3 window: products, row sums, channel sums
// with channel masking, then the final per-channel or summed result.
module cec_mac (
   input  logic                     clock,
   input  cec_pkg::mac_load_type    load,
   input  cec_pkg::mac_cfg_type     cfg,
   input  cec_pkg::window_type      window,
   output cec_pkg::result_set_type  result
);

   localparam int ProdWidth = 24;
   localparam int RowWidth  = 26;
   localparam int ChanWidth = 28;
   localparam int ResWidth  = cec_pkg::ResultWidth;

   logic signed [ProdWidth-1:0] prod_in [3][3][3];
   logic signed [ProdWidth-1:0] prod_ff [3][3][3];
   logic signed [RowWidth-1:0]  row_in  [3][3];
   logic signed [RowWidth-1:0]  row_ff  [3][3];
   logic signed [ChanWidth-1:0] chan_in [3];
   logic signed [ChanWidth-1:0] chan_ff [3];
   logic signed [ResWidth-1:0]  total;
   cec_pkg::result_set_type result_in;
   cec_pkg::result_set_type result_ff;

   // Product index order is [kernel row][kernel column][channel].
   always_comb begin
      for (int ky = 0; ky < 3; ky++) begin
         for (int kx = 0; kx < 3; kx++) begin
            for (int k = 0; k < 3; k++) begin
               prod_in[ky][kx][k] = ProdWidth'($signed(cfg.kernel[ky][kx]))
                                  * ProdWidth'($signed({1'b0, window[kx][ky][k]}));
            end
         end
      end
   end

   always_comb begin
      for (int ky = 0; ky < 3; ky++) begin
         for (int k = 0; k < 3; k++) begin
            row_in[ky][k] = RowWidth'(prod_ff[ky][0][k]) + RowWidth'(prod_ff[ky][1][k])
                          + RowWidth'(prod_ff[ky][2][k]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         chan_in[k] = ChanWidth'(row_ff[0][k]) + ChanWidth'(row_ff[1][k])
                    + ChanWidth'(row_ff[2][k]);
      end
      if (!cfg.ch1_on) begin
         chan_in[1] = '0;
      end
      if (!cfg.ch2_on) begin
         chan_in[2] = '0;
      end
   end

   always_comb begin
      total = ResWidth'(chan_ff[0]) + ResWidth'(chan_ff[1]) + ResWidth'(chan_ff[2]);
      if (cfg.keep) begin
         for (int k = 0; k < 3; k++) begin
            result_in[k] = ResWidth'(chan_ff[k]);
         end
      end else begin
         result_in[0] = total;
         result_in[1] = '0;
         result_in[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load.prod) begin
         prod_ff <= prod_in;
      end
      if (load.rows) begin
         row_ff <= row_in;
      end
      if (load.chans) begin
         chan_ff <= chan_in;
      end
      if (load.result) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

@@ sv/clamped_edge_image_convolution_core.sv @@
`default_nettype none

// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: chan_zero, chan_one, chan_two; tuser: func
// rsp      out  rsp_tvalid/rsp_tready  tdata: out_zero, out_one, out_two; tlast: frame_last
// csr      in   csr_we                 csr_addr (register index), csr_wdata
//
// One input transfer is taken every clock while req_tready is high: each transfer needs
// one line memory read and one write, so one result per clock is sustained. A result
// passes stage 1 and the window, product, row sum, channel sum and result registers
// before rsp_tvalid. Stages advance on their own, so input keeps flowing while a
// result waits on rsp_tready, until every stage behind it is full. Reset is synchronous
// and active high; it clears counters and stage valid bits and resets the configuration.

`include "clamped_edge_image_convolution_core_assert.svh"

module clamped_edge_image_convolution_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // chan_zero [7:0], chan_one [15:8], chan_two [23:16]
   input  logic        req_tuser,   // func: 0 pixel, 1 drain tick
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // out_zero [28:0], out_one [57:29], out_two [86:58], zero
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [47:0] csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam logic [12:0] MaxWidth13 = 13'(MAX_WIDTH);

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   cec_pkg::kernel_type kernel_ff;
   logic [10:0]         width_ff;
   logic [12:0]         height_ff;
   logic [1:0]          nchan_ff;
   logic                keep_ff;
   logic                geometry_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= '0;
         width_ff  <= 11'd1;
         height_ff <= 13'd1;
         nchan_ff  <= 2'd3;
         keep_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (cec_pkg::csr_index_type'(csr_addr))
            cec_pkg::CSR_KERNEL_TOP:    kernel_ff[0] <= csr_wdata;
            cec_pkg::CSR_KERNEL_MIDDLE: kernel_ff[1] <= csr_wdata;
            cec_pkg::CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_wdata;
            cec_pkg::CSR_IMAGE_WIDTH:   width_ff     <= csr_wdata[10:0];
            cec_pkg::CSR_IMAGE_HEIGHT:  height_ff    <= csr_wdata[12:0];
            cec_pkg::CSR_NUM_CHANNELS:  nchan_ff     <= csr_wdata[1:0];
            cec_pkg::CSR_KEEP_CHANNELS: keep_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A geometry write abandons the frame in progress.
   assign geometry_write = csr_we
      && ((csr_addr == cec_pkg::CSR_IMAGE_WIDTH) || (csr_addr == cec_pkg::CSR_IMAGE_HEIGHT));

   // Effective geometry: zero acts as one, oversize values are clamped.
   logic [WW-1:0] eff_w;
   logic [12:0]   eff_h;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WW'(1);
      end else if ({2'b00, width_ff} > MaxWidth13) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = 13'd1;
      end else if (height_ff > cec_pkg::HeightLimit) begin
         eff_h = cec_pkg::HeightLimit;
      end else begin
         eff_h = height_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: position counters, decided in the cycle of the transfer.
   // ---------------------------------------------------------------------
   logic [AW-1:0] in_col_ff, in_col_in;
   logic [12:0]   in_row_ff, in_row_in;
   logic [AW-1:0] out_col_ff, out_col_in;
   logic [12:0]   out_row_ff, out_row_in;

   logic          accept;
   logic          ignore;
   logic          step;
   logic          row_lt_h;
   logic          col_zero;
   logic          emit_a;
   logic          emit_b;
   logic          is_last;
   logic [WW-1:0] in_col_plus;
   logic [WW-1:0] out_col_plus;
   cec_pkg::s1_ctl_type s0_ctl;

   assign row_lt_h = in_row_ff < eff_h;
   // A drain tick before the last row is in, or a pixel after it, is dropped.
   assign ignore   = req_tuser ? row_lt_h : !row_lt_h;
   assign accept   = req_tvalid && req_tready;
   assign step     = accept && !ignore;
   assign col_zero = in_col_ff == '0;

   // Emit at the start of a row: the previous row's last pixel, right edge
   // clamped. Emit mid-row: the pixel left of the new column.
   assign emit_a = col_zero && (in_row_ff >= 13'd2);
   assign emit_b = !col_zero && (in_row_ff != 13'd0);

   assign in_col_plus  = WW'(in_col_ff) + WW'(1);
   assign out_col_plus = WW'(out_col_ff) + WW'(1);
   assign is_last      = (out_row_ff >= (eff_h - 13'd1)) && (out_col_plus >= eff_w);

   always_comb begin
      s0_ctl.emit             = emit_a || emit_b;
      s0_ctl.right_is_new     = emit_b;
      s0_ctl.left_from_center = emit_a ? (eff_w == WW'(1)) : (in_col_ff == AW'(1));
      s0_ctl.top_from_a       = in_row_ff == 13'd1;
      s0_ctl.bot_from_a       = !row_lt_h;
      s0_ctl.do_shift         = in_row_ff <= eff_h;
      s0_ctl.do_write         = row_lt_h;
      s0_ctl.frame_last       = is_last;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (geometry_write || (step && s0_ctl.emit && is_last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (step) begin
         if (in_col_plus >= eff_w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 13'd1;
         end else begin
            in_col_in = in_col_plus[AW-1:0];
         end
         if (s0_ctl.emit) begin
            if (out_col_plus >= eff_w) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 13'd1;
            end else begin
               out_col_in = out_col_plus[AW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline handshake. Each stage takes new data when it is empty or its
   // content moves on in the same cycle.
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;
   logic l2_ff, l3_ff, l4_ff, l5_ff, lo_ff;
   logic ready_o, ready5, ready4, ready3, ready2, ready1;
   logic leave1;
   cec_pkg::s1_ctl_type s1_ctl_ff;
   cec_pkg::pixel_type  s1_pix_ff;
   logic [AW-1:0]       s1_addr_ff;

   assign ready_o = !vo_ff || rsp_tready;
   assign ready5  = !v5_ff || ready_o;
   assign ready4  = !v4_ff || ready5;
   assign ready3  = !v3_ff || ready4;
   assign ready2  = !v2_ff || ready3;
   // An item that emits nothing only updates the window and line memories.
   assign leave1  = v1_ff && (!s1_ctl_ff.emit || ready2);
   assign ready1  = !v1_ff || leave1;
   assign req_tready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= step;
         end
         if (ready2) begin
            v2_ff <= leave1 && s1_ctl_ff.emit;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
         if (ready4) begin
            v4_ff <= v3_ff;
         end
         if (ready5) begin
            v5_ff <= v4_ff;
         end
         if (ready_o) begin
            vo_ff <= v5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_ctl_ff  <= s0_ctl;
         s1_pix_ff  <= req_tdata;
         s1_addr_ff <= in_col_ff;
      end
      if (ready2) begin
         l2_ff <= s1_ctl_ff.frame_last;
      end
      if (ready3) begin
         l3_ff <= l2_ff;
      end
      if (ready4) begin
         l4_ff <= l3_ff;
      end
      if (ready5) begin
         l5_ff <= l4_ff;
      end
      if (ready_o) begin
         lo_ff <= l5_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: line memories and the window column cells.
   // ---------------------------------------------------------------------
   cec_pkg::pixel_type  line_a;
   cec_pkg::pixel_type  line_b;
   cec_pkg::column_type new_col;
   cec_pkg::column_type far_col;
   cec_pkg::column_type near_col;
   logic                win_shift;

   cec_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock    (clock),
      .rd_en    (step),
      .rd_addr  (in_col_ff),
      .wr_en    (leave1 && s1_ctl_ff.do_write),
      .wr_addr  (s1_addr_ff),
      .wr_pixel (s1_pix_ff),
      .wr_above (line_a),
      .rd_a     (line_a),
      .rd_b     (line_b)
   );

   // Top and bottom rows are clamped to the frame edge.
   always_comb begin
      new_col[0] = s1_ctl_ff.top_from_a ? line_a : line_b;
      new_col[1] = line_a;
      new_col[2] = s1_ctl_ff.bot_from_a ? line_a : s1_pix_ff;
   end

   assign win_shift = leave1 && s1_ctl_ff.do_shift;

   cec_column_cell u_cell_near (
      .clock   (clock),
      .shift   (win_shift),
      .col_in  (new_col),
      .col_out (near_col)
   );

   cec_column_cell u_cell_far (
      .clock   (clock),
      .shift   (win_shift),
      .col_in  (near_col),
      .col_out (far_col)
   );

   // ---------------------------------------------------------------------
   // Stage 2: the window seen by the multipliers, with left and right
   // columns clamped at the row ends.
   // ---------------------------------------------------------------------
   cec_pkg::window_type win_ff;

   always_ff @(posedge clock) begin
      if (ready2) begin
         win_ff[0] <= s1_ctl_ff.left_from_center ? near_col : far_col;
         win_ff[1] <= near_col;
         win_ff[2] <= s1_ctl_ff.right_is_new ? new_col : near_col;
      end
   end

   // ---------------------------------------------------------------------
   // Stages 3 to 5 and the result register.
   // ---------------------------------------------------------------------
   cec_pkg::mac_cfg_type    mac_cfg;
   cec_pkg::mac_load_type   mac_load;
   cec_pkg::result_set_type result;

   always_comb begin
      mac_cfg.kernel  = kernel_ff;
      mac_cfg.ch1_on  = nchan_ff >= 2'd2;
      mac_cfg.ch2_on  = nchan_ff == 2'd3;
      mac_cfg.keep    = keep_ff;
      mac_load.prod   = ready3;
      mac_load.rows   = ready4;
      mac_load.chans  = ready5;
      mac_load.result = ready_o;
   end

   cec_mac u_mac (
      .clock  (clock),
      .load   (mac_load),
      .cfg    (mac_cfg),
      .window (win_ff),
      .result (result)
   );

   assign rsp_tvalid = vo_ff;
   assign rsp_tlast  = lo_ff;
   assign rsp_tdata  = {1'b0, result[2], result[1], result[0]};

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `CEC_ASSERT_HOLDS(a_in_col_range, clock, reset, in_col_ff < eff_w, "input column past row end")
   `CEC_ASSERT_HOLDS(a_in_row_range, clock, reset, in_row_ff <= (eff_h + 13'd1), "row past drain")
   `CEC_ASSERT_HOLDS(a_out_row_range, clock, reset, out_row_ff < eff_h, "output row past frame")
   `CEC_ASSERT_NEXT(a_result_lands, clock, reset, v5_ff && ready_o, rsp_tvalid, "result lost")
   `CEC_ASSERT_NEXT(a_s1_holds, clock, reset, v1_ff && !leave1, v1_ff && $stable(s1_ctl_ff), "stage 1 dropped")

endmodule

`default_nettype wire
